@@ src/psme_pkg.sv @@
// Package of the p-code stack machine execute unit: codes and state type.
`default_nettype none
package psme_pkg;

    localparam logic CMD_EXEC    = 1'b0;
    localparam logic CMD_PRELOAD = 1'b1;

    localparam logic [7:0] OP_DROP = 8'o000;
    localparam logic [7:0] OP_PUSH = 8'o010;
    localparam logic [7:0] OP_LOD  = 8'o020;
    localparam logic [7:0] OP_LODA = 8'o021;
    localparam logic [7:0] OP_STO  = 8'o030;
    localparam logic [7:0] OP_STOA = 8'o031;
    localparam logic [7:0] OP_STK  = 8'o032;
    localparam logic [7:0] OP_STKA = 8'o033;
    localparam logic [7:0] OP_CAL  = 8'o040;
    localparam logic [7:0] OP_CAL2 = 8'o042;
    localparam logic [7:0] OP_INT  = 8'o050;
    localparam logic [7:0] OP_JMP  = 8'o060;
    localparam logic [7:0] OP_JPC  = 8'o070;
    localparam logic [7:0] OP_OPR  = 8'o100;
    localparam logic [7:0] OP_LDX  = 8'o110;
    localparam logic [7:0] OP_LDXA = 8'o111;
    localparam logic [7:0] OP_STX  = 8'o120;
    localparam logic [7:0] OP_STXA = 8'o121;

    localparam logic [4:0] SEL_RET  = 5'd0;
    localparam logic [4:0] SEL_NEG  = 5'd1;
    localparam logic [4:0] SEL_ADD  = 5'd2;
    localparam logic [4:0] SEL_SUB  = 5'd3;
    localparam logic [4:0] SEL_MUL  = 5'd4;
    localparam logic [4:0] SEL_DIV  = 5'd5;
    localparam logic [4:0] SEL_ODD  = 5'd6;
    localparam logic [4:0] SEL_NOT  = 5'd7;
    localparam logic [4:0] SEL_LT   = 5'd8;
    localparam logic [4:0] SEL_LE   = 5'd9;
    localparam logic [4:0] SEL_GT   = 5'd10;
    localparam logic [4:0] SEL_GE   = 5'd11;
    localparam logic [4:0] SEL_EQ   = 5'd12;
    localparam logic [4:0] SEL_NE   = 5'd13;
    localparam logic [4:0] SEL_PRI  = 5'd14;
    localparam logic [4:0] SEL_NL   = 5'd15;
    localparam logic [4:0] SEL_RDI  = 5'd16;
    localparam logic [4:0] SEL_RDC  = 5'd17;
    localparam logic [4:0] SEL_PRS  = 5'd18;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_INT  = 2'd1;
    localparam logic [1:0] KIND_NL   = 2'd2;
    localparam logic [1:0] KIND_STR  = 2'd3;

    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_OPC   = 2'd1;
    localparam logic [1:0] ERR_DIV0  = 2'd2;
    localparam logic [1:0] ERR_RANGE = 2'd3;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DEC,
        S_R1,
        S_R2,
        S_W2,
        S_DIV,
        S_DIVW,
        S_OUT
    } state_t;

endpackage
`default_nettype wire

@@ src/psme_instr_if.sv @@
// Instruction channel: command, opcode, operand and read value.
`default_nettype none
interface psme_instr_if;
    logic               valid;
    logic               ready;
    logic               command;
    logic [7:0]         opcode;
    logic signed [31:0] operand;
    logic signed [31:0] read_value;

    modport source(output valid, command, opcode, operand, read_value, input ready);
    modport sink(input valid, command, opcode, operand, read_value, output ready);
endinterface
`default_nettype wire

@@ src/psme_result_if.sv @@
// Result channel: next fetch address, output event, halt and error status.
`default_nettype none
interface psme_result_if;
    logic               valid;
    logic               ready;
    logic [15:0]        next_pc;
    logic [1:0]         out_kind;
    logic signed [31:0] out_value;
    logic               halted;
    logic [1:0]         error_code;

    modport source(output valid, next_pc, out_kind, out_value, halted, error_code,
                   input ready);
    modport sink(input valid, next_pc, out_kind, out_value, halted, error_code,
                 output ready);
endinterface
`default_nettype wire

@@ src/pcode_stack_machine_execute.sv @@
// Execute unit of a p-code stack machine with its stack memory.
// The host sends one item per instruction on instr and fetches the next
// instruction at result.next_pc of the matching result item. Each accepted
// item gives exactly one result item, in order. command 1 preloads a stack
// word at operand and sets top to it.
// The stack is one synchronous memory (one write, one registered read).
// From accept to result valid, items without a stack read (push, jump, drop,
// preload, newline, read) pass S_DEC and S_OUT; one read or a call adds S_R1
// or S_W2, two reads (binary operations, return, indexed load and store) add
// S_R1 and S_R2; divide adds S_DIV, S_DIVW (32-step restoring divider). The
// next item is accepted the cycle after the result is loaded, so the memory
// port and the sequencer set the rate. A result waits in the output register
// while the receiver stalls; the sequencer holds its finished item until
// that register is free. After reset the block clears the stack, one word a
// cycle, with instr.ready low; top is -1, frame base 0, first fetch 0.
`default_nettype none
module pcode_stack_machine_execute
    import psme_pkg::*;
#(
    parameter int STACK_DEPTH    = 4096,
    parameter int CODE_ADDR_BITS = 16
) (
    input  wire          clk,
    input  wire          rst_n,
    psme_instr_if.sink   instr,
    psme_result_if.source result
);

    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int CAB = CODE_ADDR_BITS;
    localparam int XW  = 36;
    localparam logic signed [XW-1:0] DEPTH_X = XW'(STACK_DEPTH);

    function automatic logic addr_ok(input logic signed [XW-1:0] x);
        return (x >= 0) && (x < DEPTH_X);
    endfunction

    logic [31:0] mem [STACK_DEPTH];
    logic [31:0] rdata_reg;
    logic        we;
    logic [SAW-1:0] wa, ra;
    logic [31:0] wd;

    state_t state_reg, state_next;
    logic signed [SAW:0] top_reg, top_next;
    logic [SAW-1:0] fb_reg, fb_next;
    logic [CAB-1:0] ip_reg, ip_next;
    logic [SAW-1:0] clr_reg, clr_next;

    logic               cmd_reg, cmd_next;
    logic [7:0]         op_reg, op_next;
    logic signed [31:0] opnd_reg, opnd_next;
    logic [31:0]        rv_reg, rv_next;
    logic [31:0]        x_reg, x_next;

    logic [1:0]  res_kind_reg, res_kind_next;
    logic [31:0] res_val_reg, res_val_next;
    logic        res_halt_reg, res_halt_next;
    logic [1:0]  res_err_reg, res_err_next;

    logic [31:0] dq_reg, dq_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] dvs_reg, dvs_next;
    logic        neg_reg, neg_next;
    logic [4:0]  cnt_reg, cnt_next;

    logic        ovalid_reg, ovalid_next;
    logic [15:0] o_npc_reg, o_npc_next;
    logic [1:0]  o_kind_reg, o_kind_next;
    logic [31:0] o_val_reg, o_val_next;
    logic        o_halt_reg, o_halt_next;
    logic [1:0]  o_err_reg, o_err_next;

    logic signed [XW-1:0] t_x, fb_x, a_x, w_x, base_x, ax_x, idx_x;
    logic [CAB-1:0] ipn, ip_jump, npc;
    logic           sel_ok;
    logic [4:0]     sel;
    logic [31:0]    prod, abs_x, abs_y, quot;
    logic [32:0]    rem_sh, diff;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        rdata_reg <= mem[ra];
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg    <= S_CLEAR;
            top_reg      <= '1;
            fb_reg       <= '0;
            ip_reg       <= '1;
            clr_reg      <= '0;
            ovalid_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            top_reg      <= top_next;
            fb_reg       <= fb_next;
            ip_reg       <= ip_next;
            clr_reg      <= clr_next;
            ovalid_reg   <= ovalid_next;
        end
    end

    always_ff @(posedge clk) begin
        cmd_reg      <= cmd_next;
        op_reg       <= op_next;
        opnd_reg     <= opnd_next;
        rv_reg       <= rv_next;
        x_reg        <= x_next;
        res_kind_reg <= res_kind_next;
        res_val_reg  <= res_val_next;
        res_halt_reg <= res_halt_next;
        res_err_reg  <= res_err_next;
        dq_reg       <= dq_next;
        rem_reg      <= rem_next;
        dvs_reg      <= dvs_next;
        neg_reg      <= neg_next;
        cnt_reg      <= cnt_next;
        o_npc_reg    <= o_npc_next;
        o_kind_reg   <= o_kind_next;
        o_val_reg    <= o_val_next;
        o_halt_reg   <= o_halt_next;
        o_err_reg    <= o_err_next;
    end

    assign t_x     = XW'(top_reg);
    assign fb_x    = XW'({1'b0, fb_reg});
    assign a_x     = XW'(opnd_reg);
    assign w_x     = XW'($signed(rdata_reg));
    assign base_x  = op_reg[0] ? '0 : fb_x;
    assign ax_x    = base_x + a_x;
    assign idx_x   = ax_x + w_x;
    assign ipn     = ip_reg + CAB'(1);
    assign ip_jump = opnd_reg[CAB-1:0] - CAB'(1);
    assign npc     = ip_reg + CAB'(1);
    assign sel_ok  = (opnd_reg[31:5] == '0);
    assign sel     = opnd_reg[4:0];
    assign prod    = x_reg * rdata_reg;
    assign abs_x   = x_reg[31] ? 32'd0 - x_reg : x_reg;
    assign abs_y   = rdata_reg[31] ? 32'd0 - rdata_reg : rdata_reg;
    assign rem_sh  = {rem_reg, dq_reg[31]};
    assign diff    = rem_sh - {1'b0, dvs_reg};
    assign quot    = neg_reg ? 32'd0 - dq_reg : dq_reg;

    assign instr.ready       = (state_reg == S_IDLE);
    assign result.valid      = ovalid_reg;
    assign result.next_pc    = o_npc_reg;
    assign result.out_kind   = o_kind_reg;
    assign result.out_value  = o_val_reg;
    assign result.halted     = o_halt_reg;
    assign result.error_code = o_err_reg;

    always_comb begin
        state_next    = state_reg;
        top_next      = top_reg;
        fb_next       = fb_reg;
        ip_next       = ip_reg;
        clr_next      = clr_reg;
        cmd_next      = cmd_reg;
        op_next       = op_reg;
        opnd_next     = opnd_reg;
        rv_next       = rv_reg;
        x_next        = x_reg;
        res_kind_next = res_kind_reg;
        res_val_next  = res_val_reg;
        res_halt_next = res_halt_reg;
        res_err_next  = res_err_reg;
        dq_next       = dq_reg;
        rem_next      = rem_reg;
        dvs_next      = dvs_reg;
        neg_next      = neg_reg;
        cnt_next      = cnt_reg;
        ovalid_next   = ovalid_reg && !result.ready;
        o_npc_next    = o_npc_reg;
        o_kind_next   = o_kind_reg;
        o_val_next    = o_val_reg;
        o_halt_next   = o_halt_reg;
        o_err_next    = o_err_reg;
        we = 1'b0;
        wa = '0;
        wd = '0;
        ra = '0;

        case (state_reg)
            S_CLEAR: begin
                we       = 1'b1;
                wa       = clr_reg;
                clr_next = clr_reg + SAW'(1);
                if (clr_reg == SAW'(STACK_DEPTH - 1)) begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE: begin
                if (instr.valid) begin
                    cmd_next      = instr.command;
                    op_next       = instr.opcode;
                    opnd_next     = instr.operand;
                    rv_next       = instr.read_value;
                    res_kind_next = KIND_NONE;
                    res_val_next  = '0;
                    res_halt_next = 1'b0;
                    res_err_next  = ERR_OK;
                    state_next    = S_DEC;
                end
            end

            S_DEC: begin
                state_next = S_OUT;
                if (cmd_reg == CMD_PRELOAD) begin
                    if (addr_ok(a_x)) begin
                        we       = 1'b1;
                        wa       = a_x[SAW-1:0];
                        wd       = rv_reg;
                        top_next = a_x[SAW:0];
                    end else begin
                        res_err_next = ERR_RANGE;
                    end
                end else begin
                    ip_next = ipn;
                    case (op_reg)
                        OP_DROP, OP_INT: begin
                            if (op_reg == OP_DROP) begin
                                x_next = 32'(t_x - a_x);
                            end
                            if ((op_reg == OP_DROP ? t_x - a_x : t_x + a_x) < -1 ||
                                !addr_ok(op_reg == OP_DROP ? t_x - a_x : t_x + a_x) &&
                                (op_reg == OP_DROP ? t_x - a_x : t_x + a_x) >= 0) begin
                                res_err_next = ERR_RANGE;
                            end else begin
                                top_next = op_reg == OP_DROP ? (SAW+1)'(t_x - a_x)
                                         : (SAW+1)'(t_x + a_x);
                            end
                        end
                        OP_PUSH: begin
                            if (addr_ok(t_x + 1)) begin
                                we       = 1'b1;
                                wa       = SAW'(t_x + 1);
                                wd       = opnd_reg;
                                top_next = (SAW+1)'(t_x + 1);
                            end else begin
                                res_err_next = ERR_RANGE;
                            end
                        end
                        OP_LOD, OP_LODA: begin
                            ra = ax_x[SAW-1:0];
                            if (addr_ok(t_x + 1) && addr_ok(ax_x)) begin
                                state_next = S_R1;
                            end else begin
                                res_err_next = ERR_RANGE;
                            end
                        end
                        OP_STO, OP_STOA, OP_STK, OP_STKA, OP_JPC, OP_LDX, OP_LDXA: begin
                            ra = top_reg[SAW-1:0];
                            if (addr_ok(t_x) &&
                                (op_reg == OP_JPC || op_reg == OP_LDX ||
                                 op_reg == OP_LDXA || addr_ok(ax_x))) begin
                                state_next = S_R1;
                            end else begin
                                res_err_next = ERR_RANGE;
                            end
                        end
                        OP_CAL, OP_CAL2: begin
                            if (addr_ok(t_x + (op_reg == OP_CAL ? 2 : 3)) &&
                                addr_ok(t_x + (op_reg == OP_CAL ? 1 : 2))) begin
                                we       = 1'b1;
                                wa       = SAW'(t_x + (op_reg == OP_CAL ? 2 : 3));
                                wd       = 32'(ipn);
                                x_next   = 32'(fb_reg);
                                fb_next  = SAW'(t_x + (op_reg == OP_CAL ? 1 : 2));
                                top_next = (SAW+1)'(t_x + (op_reg == OP_CAL ? 2 : 3));
                                ip_next  = ip_jump;
                                state_next = S_W2;
                            end else begin
                                res_err_next = ERR_RANGE;
                            end
                        end
                        OP_JMP: begin
                            ip_next = ip_jump;
                        end
                        OP_STX, OP_STXA: begin
                            ra = SAW'(t_x - 1);
                            if (t_x >= 1 && addr_ok(t_x)) begin
                                state_next = S_R1;
                            end else begin
                                res_err_next = ERR_RANGE;
                            end
                        end
                        OP_OPR: begin
                            if (!sel_ok || sel > SEL_PRS) begin
                                res_err_next = ERR_OPC;
                            end else if (sel == SEL_RET) begin
                                ra = fb_reg;
                                if (addr_ok(fb_x + 1)) begin
                                    state_next = S_R1;
                                end else begin
                                    res_err_next = ERR_RANGE;
                                end
                            end else if (sel inside {SEL_NEG, SEL_ODD, SEL_NOT,
                                                     SEL_PRI, SEL_PRS}) begin
                                ra = top_reg[SAW-1:0];
                                if (addr_ok(t_x)) begin
                                    state_next = S_R1;
                                end else begin
                                    res_err_next = ERR_RANGE;
                                end
                            end else if (sel == SEL_NL) begin
                                res_kind_next = KIND_NL;
                            end else if (sel inside {SEL_RDI, SEL_RDC}) begin
                                if (addr_ok(t_x + 1)) begin
                                    we       = 1'b1;
                                    wa       = SAW'(t_x + 1);
                                    wd       = rv_reg;
                                    top_next = (SAW+1)'(t_x + 1);
                                end else begin
                                    res_err_next = ERR_RANGE;
                                end
                            end else begin
                                ra = SAW'(t_x - 1);
                                if (t_x >= 1 && addr_ok(t_x)) begin
                                    state_next = S_R1;
                                end else begin
                                    res_err_next = ERR_RANGE;
                                end
                            end
                        end
                        default: begin
                            res_err_next = ERR_OPC;
                        end
                    endcase
                end
            end

            S_R1: begin
                state_next = S_OUT;
                case (op_reg)
                    OP_LOD, OP_LODA: begin
                        we       = 1'b1;
                        wa       = SAW'(t_x + 1);
                        wd       = rdata_reg;
                        top_next = (SAW+1)'(t_x + 1);
                    end
                    OP_STO, OP_STOA, OP_STK, OP_STKA: begin
                        we = 1'b1;
                        wa = ax_x[SAW-1:0];
                        wd = rdata_reg;
                        if (!op_reg[1]) begin
                            top_next = (SAW+1)'(t_x - 1);
                        end
                    end
                    OP_JPC: begin
                        if (rdata_reg == '0) begin
                            ip_next = ip_jump;
                        end
                        top_next = (SAW+1)'(t_x - 1);
                    end
                    OP_LDX, OP_LDXA: begin
                        ra = idx_x[SAW-1:0];
                        if (addr_ok(idx_x)) begin
                            state_next = S_R2;
                        end else begin
                            res_err_next = ERR_RANGE;
                        end
                    end
                    OP_STX, OP_STXA: begin
                        ra     = top_reg[SAW-1:0];
                        x_next = 32'(idx_x[SAW-1:0]);
                        if (addr_ok(idx_x)) begin
                            state_next = S_R2;
                        end else begin
                            res_err_next = ERR_RANGE;
                        end
                    end
                    default: begin
                        case (sel)
                            SEL_RET: begin
                                ra     = SAW'(fb_x + 1);
                                x_next = rdata_reg;
                                if (addr_ok(w_x)) begin
                                    state_next = S_R2;
                                end else begin
                                    res_err_next = ERR_RANGE;
                                end
                            end
                            SEL_NEG, SEL_ODD, SEL_NOT: begin
                                we = 1'b1;
                                wa = top_reg[SAW-1:0];
                                if (sel == SEL_NEG) begin
                                    wd = 32'd0 - rdata_reg;
                                end else if (sel == SEL_ODD) begin
                                    wd = {31'd0, rdata_reg[0]};
                                end else begin
                                    wd = {31'd0, rdata_reg == '0};
                                end
                            end
                            SEL_PRI, SEL_PRS: begin
                                res_kind_next = (sel == SEL_PRI) ? KIND_INT : KIND_STR;
                                res_val_next  = rdata_reg;
                                top_next      = (SAW+1)'(t_x - 1);
                            end
                            default: begin
                                ra         = top_reg[SAW-1:0];
                                x_next     = rdata_reg;
                                state_next = S_R2;
                            end
                        endcase
                    end
                endcase
            end

            S_R2: begin
                state_next = S_OUT;
                case (op_reg)
                    OP_LDX, OP_LDXA: begin
                        we = 1'b1;
                        wa = top_reg[SAW-1:0];
                        wd = rdata_reg;
                    end
                    OP_STX, OP_STXA: begin
                        we       = 1'b1;
                        wa       = x_reg[SAW-1:0];
                        wd       = rdata_reg;
                        top_next = (SAW+1)'(t_x - 2);
                    end
                    default: begin
                        if (sel == SEL_RET) begin
                            ip_next       = rdata_reg[CAB-1:0];
                            top_next      = (SAW+1)'(fb_x - 1);
                            fb_next       = x_reg[SAW-1:0];
                            res_halt_next = (x_reg == '0);
                        end else if (sel == SEL_DIV) begin
                            if (rdata_reg == '0) begin
                                res_err_next = ERR_DIV0;
                            end else begin
                                dq_next    = abs_x;
                                rem_next   = '0;
                                dvs_next   = abs_y;
                                neg_next   = x_reg[31] ^ rdata_reg[31];
                                cnt_next   = '0;
                                state_next = S_DIV;
                            end
                        end else begin
                            we       = 1'b1;
                            wa       = SAW'(t_x - 1);
                            top_next = (SAW+1)'(t_x - 1);
                            case (sel)
                                SEL_ADD: wd = x_reg + rdata_reg;
                                SEL_SUB: wd = x_reg - rdata_reg;
                                SEL_MUL: wd = prod;
                                SEL_LT:  wd = {31'd0, $signed(x_reg) <  $signed(rdata_reg)};
                                SEL_LE:  wd = {31'd0, $signed(x_reg) <= $signed(rdata_reg)};
                                SEL_GT:  wd = {31'd0, $signed(x_reg) >  $signed(rdata_reg)};
                                SEL_GE:  wd = {31'd0, $signed(x_reg) >= $signed(rdata_reg)};
                                SEL_EQ:  wd = {31'd0, x_reg == rdata_reg};
                                default: wd = {31'd0, x_reg != rdata_reg};
                            endcase
                        end
                    end
                endcase
            end

            S_W2: begin
                we         = 1'b1;
                wa         = fb_reg;
                wd         = x_reg;
                state_next = S_OUT;
            end

            S_DIV: begin
                rem_next = diff[32] ? rem_sh[31:0] : diff[31:0];
                dq_next  = {dq_reg[30:0], ~diff[32]};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    state_next = S_DIVW;
                end
            end

            S_DIVW: begin
                we         = 1'b1;
                wa         = SAW'(t_x - 1);
                wd         = quot;
                top_next   = (SAW+1)'(t_x - 1);
                state_next = S_OUT;
            end

            S_OUT: begin
                if (!ovalid_reg || result.ready) begin
                    ovalid_next = 1'b1;
                    o_npc_next  = 16'(npc);
                    o_kind_next = res_kind_reg;
                    o_val_next  = res_val_reg;
                    o_halt_next = res_halt_reg;
                    o_err_next  = res_err_reg;
                    state_next  = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire
